[rtl/fsq_pkg.sv]
package fsq_pkg;

    localparam int PTS_W             = 48;
    localparam int HANDLE_W          = 32;
    localparam int OPCODE_W          = 2;
    localparam int COUNT_W           = 5;
    localparam int DEFAULT_MAX_DEPTH = 16;
    localparam logic [COUNT_W-1:0] CAPACITY_RESET = COUNT_W'(16);

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef struct packed {
        logic [PTS_W-1:0]    pts;
        logic [HANDLE_W-1:0] handle;
    } frame_t;

    typedef struct packed {
        logic                ok;
        logic [PTS_W-1:0]    out_pts;
        logic [HANDLE_W-1:0] out_handle;
        logic [COUNT_W-1:0]  count;
        logic                nonempty;
        logic [PTS_W-1:0]    front_pts;
        logic [PTS_W-1:0]    back_pts;
    } rsp_t;

endpackage

[rtl/fsq_if.sv]
interface fsq_cmd_if;
    import fsq_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [PTS_W-1:0]    frame_pts;
    logic [HANDLE_W-1:0] frame_handle;
    logic [PTS_W-1:0]    now_pts;

    modport source (output valid, output opcode, output frame_pts, output frame_handle,
                    output now_pts, input ready);
    modport sink   (input valid, input opcode, input frame_pts, input frame_handle,
                    input now_pts, output ready);
endinterface

interface fsq_rsp_if;
    import fsq_pkg::*;

    logic                valid;
    logic                ready;
    logic                ok;
    logic [PTS_W-1:0]    out_pts;
    logic [HANDLE_W-1:0] out_handle;
    logic [COUNT_W-1:0]  count;
    logic                nonempty;
    logic [PTS_W-1:0]    front_pts;
    logic [PTS_W-1:0]    back_pts;

    modport source (output valid, output ok, output out_pts, output out_handle,
                    output count, output nonempty, output front_pts, output back_pts,
                    input ready);
    modport sink   (input valid, input ok, input out_pts, input out_handle,
                    input count, input nonempty, input front_pts, input back_pts,
                    output ready);
endinterface

[rtl/fsq_mem.sv]
module fsq_mem #(
    parameter int MAX_DEPTH = fsq_pkg::DEFAULT_MAX_DEPTH,
    localparam int IDX_W = $clog2(MAX_DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  fsq_pkg::frame_t  wdata,
    input  logic [IDX_W-1:0] raddr,
    output fsq_pkg::frame_t  rdata
);
    import fsq_pkg::*;

    frame_t mem_array [MAX_DEPTH];
    frame_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        rdata_reg <= mem_array[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/fsq_ctrl.sv]
module fsq_ctrl #(
    parameter int MAX_DEPTH = fsq_pkg::DEFAULT_MAX_DEPTH,
    localparam int IDX_W = $clog2(MAX_DEPTH)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [fsq_pkg::COUNT_W-1:0] cfg_wdata,
    fsq_cmd_if.sink                     cmd,
    output logic                        res_valid,
    input  logic                        res_ready,
    output fsq_pkg::rsp_t               res,
    output logic                        mem_we,
    output logic [IDX_W-1:0]            mem_waddr,
    output fsq_pkg::frame_t             mem_wdata,
    output logic [IDX_W-1:0]            mem_raddr,
    input  fsq_pkg::frame_t             mem_rdata
);
    import fsq_pkg::*;

    localparam int EXT_W = (IDX_W + 1 > COUNT_W) ? IDX_W + 1 : COUNT_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WALK  = 4'b0010,
        S_FRONT = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] cap_reg;
    logic [COUNT_W-1:0] eff_cap;
    logic [PTS_W-1:0]   front_reg, front_next;
    logic [PTS_W-1:0]   back_reg, back_next;
    logic [PTS_W-1:0]   now_reg, now_next;
    logic [COUNT_W-1:0] chk_pos_reg, chk_pos_next;
    rsp_t               res_reg, res_next;
    logic               full;
    logic               hit;
    logic [COUNT_W-1:0] left;

    // ring position of the pos-th oldest entry
    function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] base,
                                              input logic [COUNT_W-1:0] pos);
        logic [EXT_W-1:0] sum;
        sum = EXT_W'(base) + EXT_W'(pos);
        if (sum >= EXT_W'(MAX_DEPTH))
        begin
            sum = sum - EXT_W'(MAX_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic rsp_t status(input logic [COUNT_W-1:0] n,
                                    input logic [PTS_W-1:0]   front,
                                    input logic [PTS_W-1:0]   back);
        rsp_t r;
        r            = '0;
        r.count      = n;
        r.nonempty   = (n != '0);
        r.front_pts  = (n != '0) ? front : '0;
        r.back_pts   = (n != '0) ? back : '0;
        return r;
    endfunction

    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = COUNT_W'(1);
        end
        else if (32'(cap_reg) > MAX_DEPTH)
        begin
            eff_cap = COUNT_W'(MAX_DEPTH);
        end
        else
        begin
            eff_cap = cap_reg;
        end
    end

    assign full = (count_reg >= eff_cap);
    assign hit  = (mem_rdata.pts <= now_reg);
    assign left = count_reg - chk_pos_reg - COUNT_W'(1);

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        front_next   = front_reg;
        back_next    = back_reg;
        now_next     = now_reg;
        chk_pos_next = chk_pos_reg;
        res_next     = res_reg;
        mem_we       = 1'b0;
        mem_waddr    = slot(head_reg, count_reg);
        mem_wdata    = '{pts: cmd.frame_pts, handle: cmd.frame_handle};
        mem_raddr    = head_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = S_EMIT;
                    case (opcode_t'(cmd.opcode))
                        OP_PUSH:
                        begin
                            // new word lands at head+count whether or not one is dropped
                            mem_we    = 1'b1;
                            back_next = cmd.frame_pts;
                            if (full)
                            begin
                                head_next = slot(head_reg, COUNT_W'(1));
                                if (count_reg == COUNT_W'(1))
                                begin
                                    front_next = cmd.frame_pts;
                                end
                                else
                                begin
                                    mem_raddr  = head_next;
                                    state_next = S_FRONT;
                                end
                            end
                            else
                            begin
                                count_next = count_reg + COUNT_W'(1);
                                if (count_reg == '0)
                                begin
                                    front_next = cmd.frame_pts;
                                end
                            end
                            res_next = status(count_next, front_next, back_next);
                        end
                        OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next = status(count_reg, front_reg, back_reg);
                            end
                            else
                            begin
                                mem_raddr    = slot(head_reg, count_reg - COUNT_W'(1));
                                chk_pos_next = count_reg - COUNT_W'(1);
                                now_next     = cmd.now_pts;
                                state_next   = S_WALK;
                            end
                        end
                        OP_CLEAR:
                        begin
                            head_next  = '0;
                            count_next = '0;
                            res_next   = status('0, front_reg, back_reg);
                        end
                        default:
                        begin
                            res_next = status(count_reg, front_reg, back_reg);
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                // data of chk_pos is here; fetch the next older one meanwhile
                if (chk_pos_reg != '0)
                begin
                    mem_raddr = slot(head_reg, chk_pos_reg - COUNT_W'(1));
                end
                if (hit || chk_pos_reg == '0)
                begin
                    res_next            = status(left, front_reg, back_reg);
                    res_next.ok         = 1'b1;
                    res_next.out_pts    = mem_rdata.pts;
                    res_next.out_handle = mem_rdata.handle;
                    head_next           = slot(head_reg, chk_pos_reg + COUNT_W'(1));
                    count_next          = left;
                    if (left != '0)
                    begin
                        mem_raddr  = head_next;
                        state_next = S_FRONT;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
                else
                begin
                    chk_pos_next = chk_pos_reg - COUNT_W'(1);
                end
            end
            S_FRONT:
            begin
                front_next         = mem_rdata.pts;
                res_next.front_pts = mem_rdata.pts;
                state_next         = S_EMIT;
            end
            S_EMIT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            cap_reg   <= CAPACITY_RESET;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg   <= front_next;
        back_reg    <= back_next;
        now_reg     <= now_next;
        chk_pos_reg <= chk_pos_next;
        res_reg     <= res_next;
    end

    assign cmd.ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_EMIT);
    assign res       = res_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= MAX_DEPTH)
        else $error("held count exceeds ring depth");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK |-> chk_pos_reg < count_reg)
        else $error("walk position outside held frames");

    a_push_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready && cmd.opcode == OP_PUSH)
        |=> (count_reg != '0 && count_reg >= $past(count_reg)))
        else $error("push lost frames");

    a_pop_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK && state_next != S_WALK) |=> count_reg < $past(count_reg))
        else $error("pop removed nothing");

    a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready) |=> state_reg == S_IDLE)
        else $error("sequencer not idle after handoff");

endmodule

[rtl/timestamped_frame_selector_queue.sv]
// Bounded frame queue with timestamp selection.
// cmd channel (valid/ready) takes one word per operation: push a frame
// (frame_pts, frame_handle), pop the newest frame not after now_pts (dropping
// it and all older ones, or the oldest if all are in the future), or clear.
// rsp channel returns one word per operation: ok, the delivered frame, and the
// count, nonempty, front and back timestamps after the operation.
// cfg_we/cfg_wdata write the capacity (0 acts as 1, above MAX_DEPTH acts as
// MAX_DEPTH); a push at capacity drops the oldest frame first.
// Frames sit in a one-port-read, one-port-write ring with a registered read.
// Clear, no-op, empty pop and plain push go straight to the result; a push
// that drops with more than one frame held first reads the new front; a pop
// checks k frames newest first, one per cycle through the ring read port
// (1..count), then reads the new front when frames remain after it.
// The next cmd word is taken the cycle after the result enters the rsp
// register, so a stalled rsp holds one result while the next operation runs;
// its result then waits in the sequencer until the rsp register frees.
// Reset empties the queue, sets capacity to 16 and clears rsp valid; ring
// contents are not cleared, only written entries are ever used.
module timestamped_frame_selector_queue #(
    parameter int MAX_DEPTH = fsq_pkg::DEFAULT_MAX_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [fsq_pkg::COUNT_W-1:0] cfg_wdata,
    fsq_cmd_if.sink                     cmd,
    fsq_rsp_if.source                   rsp
);
    import fsq_pkg::*;

    localparam int IDX_W = $clog2(MAX_DEPTH);

    logic             res_valid;
    logic             res_ready;
    rsp_t             res;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    frame_t           mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    frame_t           mem_rdata;
    logic             out_valid_reg;
    rsp_t             out_data_reg;

    fsq_ctrl #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    fsq_mem #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign res_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.ok         = out_data_reg.ok;
    assign rsp.out_pts    = out_data_reg.out_pts;
    assign rsp.out_handle = out_data_reg.out_handle;
    assign rsp.count      = out_data_reg.count;
    assign rsp.nonempty   = out_data_reg.nonempty;
    assign rsp.front_pts  = out_data_reg.front_pts;
    assign rsp.back_pts   = out_data_reg.back_pts;

endmodule
